/* hw/rtl/cpob_pkg.sv */
// ----------------------------------------------------------------------------
// cpob_pkg
// Types and constants shared by the closest-point-on-oriented-box unit.
// ----------------------------------------------------------------------------
package cpob_pkg;

   // Sine table defaults and formats
   localparam int SINE_TABLE_DEPTH_DEF = 1024;
   localparam int TAB_W                = 31;            // Q1.30, 0 .. 2^30
   localparam int TRIG_SHIFT           = 30;
   localparam logic [63:0] TRIG_ONE    = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int QUARTER_BITS         = 14;            // yaw units per quadrant, log2

   typedef struct packed {
      logic signed [31:0] box_center_x;
      logic signed [31:0] box_center_y;
      logic signed [31:0] box_center_z;
      logic        [15:0] box_yaw;
      logic        [30:0] half_extent_x;
      logic        [30:0] half_extent_y;
      logic        [30:0] half_extent_z;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } cpob_req_type;

   typedef struct packed {
      logic signed [31:0] nearest_x;
      logic signed [31:0] nearest_y;
      logic signed [31:0] nearest_z;
   } cpob_rsp_type;

endpackage

/* hw/rtl/cpob_sine_rom.sv */
// ----------------------------------------------------------------------------
// cpob_sine_rom
// Quarter-wave sine table, Q1.30, with two registered read ports.
// ----------------------------------------------------------------------------
module cpob_sine_rom #(
   parameter int SINE_TABLE_DEPTH = cpob_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]   addr_a,
   input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]   addr_b,
   output logic [cpob_pkg::TAB_W-1:0]              data_a,
   output logic [cpob_pkg::TAB_W-1:0]              data_b
);
   import cpob_pkg::*;

   typedef logic [TAB_W-1:0] rom_type [SINE_TABLE_DEPTH+1];

   // Entry i = sin(i*pi/(2*depth)) by a truncated Taylor series up to x^15/15!
   function automatic rom_type build_rom();
      rom_type            t;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [65:0] sum;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (64'(i) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> TRIG_SHIFT;
         term = x;
         sum  = $signed({2'b00, x});
         term = ((term * x2) >> TRIG_SHIFT) / 64'd6;
         sum  = sum - $signed({2'b00, term});
         term = ((term * x2) >> TRIG_SHIFT) / 64'd20;
         sum  = sum + $signed({2'b00, term});
         term = ((term * x2) >> TRIG_SHIFT) / 64'd42;
         sum  = sum - $signed({2'b00, term});
         term = ((term * x2) >> TRIG_SHIFT) / 64'd72;
         sum  = sum + $signed({2'b00, term});
         term = ((term * x2) >> TRIG_SHIFT) / 64'd110;
         sum  = sum - $signed({2'b00, term});
         term = ((term * x2) >> TRIG_SHIFT) / 64'd156;
         sum  = sum + $signed({2'b00, term});
         term = ((term * x2) >> TRIG_SHIFT) / 64'd210;
         sum  = sum - $signed({2'b00, term});
         if (sum < 0) begin
            sum = '0;
         end
         if (sum > $signed({2'b00, TRIG_ONE})) begin
            sum = $signed({2'b00, TRIG_ONE});
         end
         t[i] = sum[TAB_W-1:0];
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [TAB_W-1:0] data_a_ff;
   logic [TAB_W-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         data_a_ff <= SINE_ROM[addr_a];
         data_b_ff <= SINE_ROM[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

/* hw/rtl/closest_point_on_oriented_box_unit.sv */
// ----------------------------------------------------------------------------
// closest_point_on_oriented_box_unit
// Clamps a query point into a yawed box and returns the closest box point.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake           | payload
//   req_     | in        | req_valid/req_stall | cpob_req_type (box, yaw, point)
//   rsp_     | out       | rsp_valid/rsp_stall | cpob_rsp_type (nearest x/y/z)
//
// Eight register stages; one item enters per cycle while req_stall is low.
// Stage one holds the sine ROM read (two ports, sin and cos of the quadrant).
// Reset clears only the stage valid bits.
// A stage loads when it is empty or the stage after it moves, so bubbles
// collapse under rsp_stall and req_stall rises only when all stages are full.
// ----------------------------------------------------------------------------
module closest_point_on_oriented_box_unit #(
   parameter int SINE_TABLE_DEPTH = cpob_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cpob_pkg::cpob_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cpob_pkg::cpob_rsp_type rsp_data
);
   import cpob_pkg::*;

   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int STAGES = 8;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic [14:0]        QUARTER_U = 15'(1 << QUARTER_BITS);
   localparam logic signed [64:0] HALF_ULP  = 65'sh20000000;
   localparam logic signed [35:0] SAT_MAX   = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] SAT_MIN   = 36'shF_8000_0000;

   function automatic logic signed [31:0] clamp_h(input logic signed [35:0] v,
                                                  input logic [30:0]        h);
      logic signed [35:0] hs;
      logic signed [35:0] r;
      hs = $signed({5'b00000, h});
      if (v < -hs) begin
         r = -hs;
      end else if (v > hs) begin
         r = hs;
      end else begin
         r = v;
      end
      return r[31:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [35:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX;
      end else if (v < SAT_MIN) begin
         r = SAT_MIN;
      end else begin
         r = v;
      end
      return r[31:0];
   endfunction

   // ---------------- pipeline control ----------------
   logic [STAGES:1] valid_ff;
   logic [STAGES:1] valid_in;
   logic [STAGES:1] adv;

   always_comb begin
      adv[STAGES] = !valid_ff[STAGES] || !rsp_stall;
      for (int k = STAGES - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      if (adv[1]) begin
         valid_in[1] = req_valid;
      end else begin
         valid_in[1] = valid_ff[1];
      end
      for (int k = 2; k <= STAGES; k++) begin
         if (adv[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !adv[1];
   assign rsp_valid = valid_ff[STAGES];

   // ---------------- stage 1: offsets, sine ROM read ----------------
   logic [14:0]      u_r;
   logic [14:0]      u_q;
   logic [31:0]      prod_r;
   logic [31:0]      prod_q;
   logic [IDX_W-1:0] idx_r;
   logic [IDX_W-1:0] idx_q;
   logic [TAB_W-1:0] rom_r;
   logic [TAB_W-1:0] rom_q;

   always_comb begin
      u_r    = {1'b0, req_data.box_yaw[QUARTER_BITS-1:0]};
      u_q    = QUARTER_U - u_r;
      prod_r = 32'(u_r) * 32'(unsigned'(SINE_TABLE_DEPTH));
      prod_q = 32'(u_q) * 32'(unsigned'(SINE_TABLE_DEPTH));
      idx_r  = prod_r[QUARTER_BITS +: IDX_W];
      idx_q  = prod_q[QUARTER_BITS +: IDX_W];
   end

   cpob_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_rom (
      .clock  (clock),
      .en     (adv[1]),
      .addr_a (idx_r),
      .addr_b (idx_q),
      .data_a (rom_r),
      .data_b (rom_q)
   );

   logic signed [32:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic [1:0]         s1_quad_ff;
   logic signed [31:0] s1_cx_ff, s1_cy_ff, s1_cz_ff;
   logic [30:0]        s1_hx_ff, s1_hy_ff, s1_hz_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_dx_ff   <= 33'(req_data.point_x) - 33'(req_data.box_center_x);
         s1_dy_ff   <= 33'(req_data.point_y) - 33'(req_data.box_center_y);
         s1_dz_ff   <= 33'(req_data.point_z) - 33'(req_data.box_center_z);
         s1_quad_ff <= req_data.box_yaw[15:14];
         s1_cx_ff   <= req_data.box_center_x;
         s1_cy_ff   <= req_data.box_center_y;
         s1_cz_ff   <= req_data.box_center_z;
         s1_hx_ff   <= req_data.half_extent_x;
         s1_hy_ff   <= req_data.half_extent_y;
         s1_hz_ff   <= req_data.half_extent_z;
      end
   end

   // ---------------- stage 2: sin/cos by quadrant ----------------
   logic signed [31:0] pos_r, pos_q;
   logic signed [31:0] s2_sin_in, s2_cos_in;

   always_comb begin
      pos_r = $signed({1'b0, rom_r});
      pos_q = $signed({1'b0, rom_q});
      unique case (s1_quad_ff)
         QUAD_0: begin
            s2_sin_in = pos_r;
            s2_cos_in = pos_q;
         end
         QUAD_1: begin
            s2_sin_in = pos_q;
            s2_cos_in = -pos_r;
         end
         QUAD_2: begin
            s2_sin_in = -pos_r;
            s2_cos_in = -pos_q;
         end
         QUAD_3: begin
            s2_sin_in = -pos_q;
            s2_cos_in = pos_r;
         end
      endcase
   end

   logic signed [31:0] s2_sin_ff, s2_cos_ff;
   logic signed [32:0] s2_dx_ff, s2_dy_ff, s2_dz_ff;
   logic signed [31:0] s2_cx_ff, s2_cy_ff, s2_cz_ff;
   logic [30:0]        s2_hx_ff, s2_hy_ff, s2_hz_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_sin_ff <= s2_sin_in;
         s2_cos_ff <= s2_cos_in;
         s2_dx_ff  <= s1_dx_ff;
         s2_dy_ff  <= s1_dy_ff;
         s2_dz_ff  <= s1_dz_ff;
         s2_cx_ff  <= s1_cx_ff;
         s2_cy_ff  <= s1_cy_ff;
         s2_cz_ff  <= s1_cz_ff;
         s2_hx_ff  <= s1_hx_ff;
         s2_hy_ff  <= s1_hy_ff;
         s2_hz_ff  <= s1_hz_ff;
      end
   end

   // ---------------- stage 3: projection products ----------------
   logic signed [64:0] s3_xc_ff, s3_ys_ff, s3_yc_ff, s3_xs_ff;
   logic signed [31:0] s3_sin_ff, s3_cos_ff;
   logic signed [32:0] s3_dz_ff;
   logic signed [31:0] s3_cx_ff, s3_cy_ff, s3_cz_ff;
   logic [30:0]        s3_hx_ff, s3_hy_ff, s3_hz_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_xc_ff  <= 65'(s2_dx_ff) * 65'(s2_cos_ff);
         s3_ys_ff  <= 65'(s2_dy_ff) * 65'(s2_sin_ff);
         s3_yc_ff  <= 65'(s2_dy_ff) * 65'(s2_cos_ff);
         s3_xs_ff  <= 65'(s2_dx_ff) * 65'(s2_sin_ff);
         s3_sin_ff <= s2_sin_ff;
         s3_cos_ff <= s2_cos_ff;
         s3_dz_ff  <= s2_dz_ff;
         s3_cx_ff  <= s2_cx_ff;
         s3_cy_ff  <= s2_cy_ff;
         s3_cz_ff  <= s2_cz_ff;
         s3_hx_ff  <= s2_hx_ff;
         s3_hy_ff  <= s2_hy_ff;
         s3_hz_ff  <= s2_hz_ff;
      end
   end

   // ---------------- stage 4: projection sums, z clamp ----------------
   logic signed [64:0] s4_ax_ff, s4_ay_ff;
   logic signed [31:0] s4_lz_ff;
   logic signed [31:0] s4_sin_ff, s4_cos_ff;
   logic signed [31:0] s4_cx_ff, s4_cy_ff, s4_cz_ff;
   logic [30:0]        s4_hx_ff, s4_hy_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_ax_ff  <= s3_xc_ff + s3_ys_ff + HALF_ULP;
         s4_ay_ff  <= s3_yc_ff - s3_xs_ff + HALF_ULP;
         s4_lz_ff  <= clamp_h(36'(s3_dz_ff), s3_hz_ff);
         s4_sin_ff <= s3_sin_ff;
         s4_cos_ff <= s3_cos_ff;
         s4_cx_ff  <= s3_cx_ff;
         s4_cy_ff  <= s3_cy_ff;
         s4_cz_ff  <= s3_cz_ff;
         s4_hx_ff  <= s3_hx_ff;
         s4_hy_ff  <= s3_hy_ff;
      end
   end

   // ---------------- stage 5: round and clamp local x/y ----------------
   logic signed [35:0] s5_fx_in, s5_fy_in;

   always_comb begin
      s5_fx_in = 36'($signed(s4_ax_ff[64:TRIG_SHIFT]));
      s5_fy_in = 36'($signed(s4_ay_ff[64:TRIG_SHIFT]));
   end

   logic signed [31:0] s5_lx_ff, s5_ly_ff, s5_lz_ff;
   logic signed [31:0] s5_sin_ff, s5_cos_ff;
   logic signed [31:0] s5_cx_ff, s5_cy_ff, s5_cz_ff;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_lx_ff  <= clamp_h(s5_fx_in, s4_hx_ff);
         s5_ly_ff  <= clamp_h(s5_fy_in, s4_hy_ff);
         s5_lz_ff  <= s4_lz_ff;
         s5_sin_ff <= s4_sin_ff;
         s5_cos_ff <= s4_cos_ff;
         s5_cx_ff  <= s4_cx_ff;
         s5_cy_ff  <= s4_cy_ff;
         s5_cz_ff  <= s4_cz_ff;
      end
   end

   // ---------------- stage 6: rebuild products ----------------
   logic signed [63:0] s6_clx_ff, s6_sly_ff, s6_slx_ff, s6_cly_ff;
   logic signed [31:0] s6_cx_ff, s6_cy_ff;
   logic signed [35:0] s6_oz_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_clx_ff <= 64'(s5_cos_ff) * 64'(s5_lx_ff);
         s6_sly_ff <= 64'(s5_sin_ff) * 64'(s5_ly_ff);
         s6_slx_ff <= 64'(s5_sin_ff) * 64'(s5_lx_ff);
         s6_cly_ff <= 64'(s5_cos_ff) * 64'(s5_ly_ff);
         s6_cx_ff  <= s5_cx_ff;
         s6_cy_ff  <= s5_cy_ff;
         s6_oz_ff  <= 36'(s5_cz_ff) + 36'(s5_lz_ff);
      end
   end

   // ---------------- stage 7: rebuild sums ----------------
   logic signed [64:0] s7_bx_ff, s7_by_ff;
   logic signed [31:0] s7_cx_ff, s7_cy_ff;
   logic signed [35:0] s7_oz_ff;

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_bx_ff <= 65'(s6_clx_ff) - 65'(s6_sly_ff) + HALF_ULP;
         s7_by_ff <= 65'(s6_slx_ff) + 65'(s6_cly_ff) + HALF_ULP;
         s7_cx_ff <= s6_cx_ff;
         s7_cy_ff <= s6_cy_ff;
         s7_oz_ff <= s6_oz_ff;
      end
   end

   // ---------------- stage 8: add center, saturate, output register ----------------
   logic signed [35:0] s8_ox_in, s8_oy_in;
   cpob_rsp_type       rsp_data_ff;

   always_comb begin
      s8_ox_in = 36'(s7_cx_ff) + 36'($signed(s7_bx_ff[64:TRIG_SHIFT]));
      s8_oy_in = 36'(s7_cy_ff) + 36'($signed(s7_by_ff[64:TRIG_SHIFT]));
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         rsp_data_ff.nearest_x <= sat32(s8_ox_in);
         rsp_data_ff.nearest_y <= sat32(s8_oy_in);
         rsp_data_ff.nearest_z <= sat32(s7_oz_ff);
      end
   end

   assign rsp_data = rsp_data_ff;

   // ---------------- assertions ----------------
   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[1])
      else $error("accepted item did not enter stage one");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid_ff == '1))
      else $error("input stalled while a pipeline stage was empty");

   a_last_stage_reaches_output: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] && adv[STAGES] |=> rsp_valid)
      else $error("item lost between last stages");

endmodule
